FILE: rtl/xsr_pkg.sv
// Types and constants shared by the xoshiro256++ generator unit.
// No dependencies; all other files refer to it by scoped names.
`default_nettype none
package xsr_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] range_low;
        logic [63:0] range_high;
    } in_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic        empty_range;
    } out_item_t;

    // mode codes
    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_RANGE = 2'd1;
    localparam logic [1:0] MODE_JUMP  = 2'd2;
    localparam logic [1:0] MODE_LJUMP = 2'd3;

    // classified operation codes
    localparam logic [2:0] OP_RAW   = 3'd0;
    localparam logic [2:0] OP_RANGE = 3'd1;
    localparam logic [2:0] OP_EMPTY = 3'd2;
    localparam logic [2:0] OP_JUMP  = 3'd3;
    localparam logic [2:0] OP_LJUMP = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] low;
        logic [63:0] span;
    } entry_t;

    typedef logic [3:0][63:0] words_t;

    localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

    localparam logic [255:0] JUMP_POLY = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
    localparam logic [255:0] LJUMP_POLY = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

    function automatic logic [63:0] draw_result(input words_t w);
        logic [63:0] s;
        s = w[0] + w[3];
        return {s[40:0], s[63:41]} + w[0];
    endfunction

    function automatic words_t draw_next(input words_t w);
        words_t n;
        logic [63:0] t;
        t = {w[1][46:0], 17'b0};
        n = w;
        n[2] = n[2] ^ n[0];
        n[3] = n[3] ^ n[1];
        n[1] = n[1] ^ n[2];
        n[0] = n[0] ^ n[3];
        n[2] = n[2] ^ t;
        n[3] = {n[3][18:0], n[3][63:19]};
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/xoshiro256pp_generator_unit.sv
// xoshiro256++ generator unit: raw draws at one item per cycle while the output is not
// stalled and no range draw, jump or reseed is busy (queue entry, then the output
// register). Range draws run the bit-serial modulo twice and draw again per rejected
// draw; jumps run the jump sequencer. After reset, and after each seed write, a splitmix
// reseed runs on the shared 32x32 multiplier before the next item is served. Reset loads seed 0.
// Depends on xsr_pkg, xsr_front, xsr_queue and xsr_back.
`default_nettype none
module xoshiro256pp_generator_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  xsr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output xsr_pkg::out_item_t out_data,
    input  wire logic          cfg_we,
    input  wire logic [63:0]   cfg_wdata
);

    logic            push, q_full, q_valid, pop;
    xsr_pkg::entry_t push_data, q_data;

    xsr_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    xsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    xsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/xsr_front.sv
// Front end: accepts input items and classifies them into queue entries.
// Depends on xsr_pkg.
`default_nettype none
module xsr_front (
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  xsr_pkg::in_item_t     in_data,
    output logic                  push,
    output xsr_pkg::entry_t       push_data,
    input  wire logic             q_full
);

    logic [64:0] diff;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign diff     = {1'b0, in_data.range_high} - {1'b0, in_data.range_low};

    always_comb
    begin
        push_data.low  = in_data.range_low;
        push_data.span = diff[63:0];
        case (in_data.mode)
            xsr_pkg::MODE_RAW:   push_data.op = xsr_pkg::OP_RAW;
            // borrow or zero difference means low is not below high
            xsr_pkg::MODE_RANGE: push_data.op = (diff[64] || diff[63:0] == 64'd0) ?
                                     xsr_pkg::OP_EMPTY : xsr_pkg::OP_RANGE;
            xsr_pkg::MODE_JUMP:  push_data.op = xsr_pkg::OP_JUMP;
            default:             push_data.op = xsr_pkg::OP_LJUMP;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/xsr_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on xsr_pkg.
`default_nettype none
module xsr_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  xsr_pkg::entry_t  push_data,
    output logic             full,
    input  wire logic        pop,
    output logic             q_valid,
    output xsr_pkg::entry_t  q_data
);

    xsr_pkg::entry_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/xsr_back.sv
// Back end: generator state, splitmix reseed sequencer, bit-serial modulo,
// rejection loop, jump sequencer and the output register. Depends on xsr_pkg.
`default_nettype none
module xsr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [63:0]   cfg_wdata,
    input  wire logic          q_valid,
    input  xsr_pkg::entry_t    q_data,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output xsr_pkg::out_item_t out_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SADD  = 4'd1;
    localparam logic [3:0] S_SMUL1 = 4'd2;
    localparam logic [3:0] S_SMUL2 = 4'd3;
    localparam logic [3:0] S_THR   = 4'd4;
    localparam logic [3:0] S_DRAW  = 4'd5;
    localparam logic [3:0] S_REM   = 4'd6;
    localparam logic [3:0] S_JUMP  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]       state_reg;
    xsr_pkg::words_t  w_reg;
    logic [63:0]      ctr_reg;
    logic [63:0]      z_reg;
    logic [63:0]      acc_reg;
    logic [1:0]       mstep_reg;
    logic [1:0]       widx_reg;
    logic [63:0]      low_reg, span_reg, thresh_reg;
    logic [63:0]      num_reg, rem_reg;
    logic [5:0]       dcnt_reg;
    logic [7:0]       jcnt_reg;
    logic             long_reg;
    xsr_pkg::words_t  jacc_reg;
    logic [63:0]      res_reg;
    logic             flag_reg;
    logic             out_valid_reg;
    xsr_pkg::out_item_t out_reg;

    logic             out_free;
    logic             out_load;
    logic [63:0]      draw_val;
    xsr_pkg::words_t  draw_w;
    logic [31:0]      ma, mb;
    logic [63:0]      mconst, pp, acc_add;
    logic [63:0]      ctr_add;
    logic [64:0]      rem_sh;
    logic [63:0]      rem_new;
    logic             jbit;
    xsr_pkg::words_t  jacc_new;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign draw_val  = xsr_pkg::draw_result(w_reg);
    assign draw_w    = xsr_pkg::draw_next(w_reg);

    assign pop = state_reg == S_IDLE && q_valid &&
                 (out_free || (q_data.op != xsr_pkg::OP_RAW && q_data.op != xsr_pkg::OP_EMPTY));

    // a new item enters the output register this cycle
    assign out_load = !cfg_we &&
                      ((pop && (q_data.op == xsr_pkg::OP_RAW || q_data.op == xsr_pkg::OP_EMPTY)) ||
                       (state_reg == S_DONE && out_free));

    // one 32x32 partial product a cycle for the low half of a 64x64 multiply
    assign mconst  = (state_reg == S_SMUL1) ? xsr_pkg::SM_MUL1 : xsr_pkg::SM_MUL2;
    assign ma      = (mstep_reg == 2'd2) ? z_reg[63:32] : z_reg[31:0];
    assign mb      = (mstep_reg == 2'd1) ? mconst[63:32] : mconst[31:0];
    assign pp      = ma * mb;
    assign acc_add = (mstep_reg == 2'd0) ? pp : {pp[31:0], 32'b0};
    assign ctr_add = ctr_reg + xsr_pkg::SM_GAMMA;

    // restoring modulo, one numerator bit a cycle
    assign rem_sh  = {rem_reg, num_reg[63]};
    assign rem_new = (rem_sh >= {1'b0, span_reg}) ? 64'(rem_sh - {1'b0, span_reg}) :
                                                    rem_sh[63:0];

    assign jbit = long_reg ? xsr_pkg::LJUMP_POLY[jcnt_reg] : xsr_pkg::JUMP_POLY[jcnt_reg];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            jacc_new[i] = jbit ? (jacc_reg[i] ^ w_reg[i]) : jacc_reg[i];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    low_reg  <= q_data.low;
                    span_reg <= q_data.span;
                    num_reg  <= 64'd0 - q_data.span;
                    rem_reg  <= 64'd0;
                    jacc_reg <= '0;
                    if (q_data.op == xsr_pkg::OP_RAW)
                    begin
                        w_reg <= draw_w;
                    end
                end
            end
            S_SADD:
            begin
                z_reg   <= ctr_add ^ (ctr_add >> 30);
                acc_reg <= 64'd0;
            end
            S_SMUL1:
            begin
                if (mstep_reg == 2'd3)
                begin
                    z_reg   <= acc_reg ^ (acc_reg >> 27);
                    acc_reg <= 64'd0;
                end
                else
                begin
                    acc_reg <= acc_reg + acc_add;
                end
            end
            S_SMUL2:
            begin
                if (mstep_reg == 2'd3)
                begin
                    w_reg[widx_reg] <= acc_reg ^ (acc_reg >> 31);
                end
                else
                begin
                    acc_reg <= acc_reg + acc_add;
                end
            end
            S_THR:
            begin
                rem_reg <= rem_new;
                num_reg <= {num_reg[62:0], 1'b0};
                if (dcnt_reg == 6'd63)
                begin
                    thresh_reg <= rem_new;
                end
            end
            S_DRAW:
            begin
                w_reg   <= draw_w;
                num_reg <= draw_val;
                rem_reg <= 64'd0;
            end
            S_REM:
            begin
                rem_reg <= rem_new;
                num_reg <= {num_reg[62:0], 1'b0};
                if (dcnt_reg == 6'd63)
                begin
                    res_reg <= low_reg + rem_new;
                end
            end
            S_JUMP:
            begin
                jacc_reg <= jacc_new;
                w_reg    <= (jcnt_reg == 8'hff) ? jacc_new : draw_w;
                res_reg  <= 64'd0;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SADD;
            ctr_reg       <= 64'd0;
            widx_reg      <= 2'd0;
            mstep_reg     <= 2'd0;
            dcnt_reg      <= 6'd0;
            jcnt_reg      <= 8'd0;
            long_reg      <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                // restart the reseed sequence from the new seed
                ctr_reg   <= cfg_wdata;
                widx_reg  <= 2'd0;
                state_reg <= S_SADD;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        dcnt_reg <= 6'd0;
                        jcnt_reg <= 8'd0;
                        flag_reg <= 1'b0;
                        if (pop)
                        begin
                            long_reg <= q_data.op == xsr_pkg::OP_LJUMP;
                            case (q_data.op)
                                xsr_pkg::OP_RAW:
                                begin
                                    out_valid_reg       <= 1'b1;
                                    out_reg.value       <= draw_val;
                                    out_reg.empty_range <= 1'b0;
                                end
                                xsr_pkg::OP_EMPTY:
                                begin
                                    out_valid_reg       <= 1'b1;
                                    out_reg.value       <= q_data.low;
                                    out_reg.empty_range <= 1'b1;
                                end
                                xsr_pkg::OP_RANGE: state_reg <= S_THR;
                                default:           state_reg <= S_JUMP;
                            endcase
                        end
                    end
                    S_SADD:
                    begin
                        ctr_reg   <= ctr_add;
                        mstep_reg <= 2'd0;
                        state_reg <= S_SMUL1;
                    end
                    S_SMUL1:
                    begin
                        mstep_reg <= mstep_reg + 2'd1;
                        if (mstep_reg == 2'd3)
                        begin
                            state_reg <= S_SMUL2;
                        end
                    end
                    S_SMUL2:
                    begin
                        mstep_reg <= mstep_reg + 2'd1;
                        if (mstep_reg == 2'd3)
                        begin
                            widx_reg  <= widx_reg + 2'd1;
                            state_reg <= (widx_reg == 2'd3) ? S_IDLE : S_SADD;
                        end
                    end
                    S_THR:
                    begin
                        dcnt_reg <= dcnt_reg + 6'd1;
                        if (dcnt_reg == 6'd63)
                        begin
                            state_reg <= S_DRAW;
                        end
                    end
                    S_DRAW:
                    begin
                        // drop draws below the threshold
                        if (draw_val >= thresh_reg)
                        begin
                            state_reg <= S_REM;
                        end
                    end
                    S_REM:
                    begin
                        dcnt_reg <= dcnt_reg + 6'd1;
                        if (dcnt_reg == 6'd63)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    S_JUMP:
                    begin
                        jcnt_reg <= jcnt_reg + 8'd1;
                        if (jcnt_reg == 8'hff)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    S_DONE:
                    begin
                        if (out_free)
                        begin
                            out_valid_reg       <= 1'b1;
                            out_reg.value       <= res_reg;
                            out_reg.empty_range <= flag_reg;
                            state_reg           <= S_IDLE;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

endmodule
`default_nettype wire
